// ===== rtl/core/kcm_pkg.sv =====
// kcm_pkg: shared types and constants for the key chord matcher.
// Used by kcm_cell and key_chord_matcher_with_cooldown; no dependencies.
package kcm_pkg;

    localparam int MAX_CHORDS  = 16;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = 4;
    localparam int TIMER_W     = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 72;
    localparam int S_TUSER_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 1'b0,
        CFG_TIMEOUT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_SCAN  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] pos;
        logic [KEY_W-1:0] left;
        logic [KEY_W-1:0] right;
    } tok_t;

endpackage

// ===== rtl/core/kcm_cell.sv =====
// kcm_cell: one chord table entry plus one stage of the search chain.
// Depends on kcm_pkg.
module kcm_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [kcm_pkg::KEY_W-1:0] wr_left,
    input  logic [kcm_pkg::KEY_W-1:0] wr_right,
    input  kcm_pkg::tok_t        tok_in,
    output kcm_pkg::tok_t        tok_out
);
    import kcm_pkg::*;

    logic [KEY_W-1:0] left_reg;
    logic [KEY_W-1:0] right_reg;
    tok_t             tok_reg;
    tok_t             tok_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= '0;
            right_reg <= '0;
        end else if (wr_en) begin
            left_reg  <= wr_left;
            right_reg <= wr_right;
        end
    end

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.done) begin
            if (left_reg == '0 && right_reg == '0) begin
                tok_next.done = 1'b1;
            end else if (left_reg == tok_in.left && right_reg == tok_in.right) begin
                tok_next.done = 1'b1;
                tok_next.hit  = 1'b1;
            end else begin
                tok_next.pos = tok_in.pos + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/key_chord_matcher_with_cooldown.sv =====
// key_chord_matcher_with_cooldown: chord table search with fire cooldown.
// A firing scan's token passes the 16 cell registers, then the output register, to m_tvalid.
// A new scan is taken only once the walk through the MAX_CHORDS cell chain has ended;
// a table write, a disabled scan or a second-pass scan starts no walk and leaves s_tready
// high. A waiting result stalls input only when the next scan fires before it has left.
// Synchronous reset (aresetn low) clears table, cooldown timer and control regs, not data regs.
// Depends on kcm_pkg and kcm_cell.
module key_chord_matcher_with_cooldown (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: left_keys[31:0], right_keys[63:32], entry_index[67:64], zero pad
    input  logic [kcm_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: func[0], second_pass[1]
    input  logic [kcm_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: chord_index[3:0], fired_left[35:4], fired_right[67:36], zero pad
    output logic [kcm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kcm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kcm_pkg::*;

    state_t               state_reg, state_next;
    logic                 enable_reg;
    logic [TIMER_W-1:0]   timeout_reg;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    tok_t                 hold_reg, hold_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [KEY_W-1:0] in_left;
    logic [KEY_W-1:0] in_right;
    logic [IDX_W-1:0] in_idx;
    logic             in_write;
    logic             in_pass;
    logic             accept;
    logic             scan_go;
    logic             out_free;
    logic             fire;

    tok_t             chain [MAX_CHORDS+1];
    logic [MAX_CHORDS-1:0] wr_en;
    logic [MAX_CHORDS-1:0] tok_valids;

    assign in_left  = s_tdata[KEY_W-1:0];
    assign in_right = s_tdata[2*KEY_W-1:KEY_W];
    assign in_idx   = s_tdata[2*KEY_W+IDX_W-1:2*KEY_W];
    assign in_write = (func_t'(s_tuser[0]) == FUNC_WRITE);
    assign in_pass  = s_tuser[1];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign scan_go   = accept && !in_write && enable_reg && !in_pass;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        chain[0]       = '0;
        chain[0].valid = scan_go;
        chain[0].left  = in_left;
        chain[0].right = in_right;
    end

    for (genvar k = 0; k < MAX_CHORDS; k++) begin : g_cell
        assign wr_en[k]      = accept && in_write &&
                               ({1'b0, in_idx} == (IDX_W+1)'(k));
        assign tok_valids[k] = chain[k+1].valid;
        kcm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (wr_en[k]),
            .wr_left  (in_left),
            .wr_right (in_right),
            .tok_in   (chain[k]),
            .tok_out  (chain[k+1])
        );
    end

    // timer here is the value after the tick's increment
    assign fire = chain[MAX_CHORDS].valid && chain[MAX_CHORDS].hit &&
                  (timer_reg == '0 || timer_reg >= timeout_reg || timeout_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            timeout_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            timer_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            timer_reg    <= timer_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg    <= hold_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        timer_next    = timer_reg;
        hold_next     = hold_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (scan_go) begin
                    if (timer_reg != '0 && timer_reg < timeout_reg) begin
                        timer_next = timer_reg + TIMER_W'(1);
                    end
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (chain[MAX_CHORDS].valid) begin
                    if (fire) begin
                        timer_next = TIMER_W'(1);
                        hold_next  = chain[MAX_CHORDS];
                        if (out_free) begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = M_TDATA_W'({chain[MAX_CHORDS].right,
                                                        chain[MAX_CHORDS].left,
                                                        chain[MAX_CHORDS].pos});
                            state_next    = ST_IDLE;
                        end else begin
                            state_next = ST_HOLD;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({hold_reg.right, hold_reg.left, hold_reg.pos});
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // at most one search token in flight
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valids))
        else $error("more than one token in the cell chain");

    a_tail_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[MAX_CHORDS].valid |-> state_reg == ST_WALK)
        else $error("token left the chain outside a walk");

    a_fire_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && state_reg == ST_WALK |=> timer_reg == TIMER_W'(1))
        else $error("cooldown not restarted after firing");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_go |=> state_reg == ST_WALK && !s_tready)
        else $error("request taken during a walk");

endmodule
